// ----- hdl/i2cscm_pkg.sv -----
// Package for the I2C section chip model: request and result types, chip
// addresses, pin codes, fault kinds and command codes.
// No dependencies.
package i2cscm_pkg;

  localparam int unsigned BUS_COUNT_DEF = 2;
  localparam int unsigned SLOTS_PER_BUS = 4;

  localparam logic [1:0] REQ_TRANSFER = 2'd0;
  localparam logic [1:0] REQ_PIN = 2'd1;
  localparam logic [1:0] REQ_FAULT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_BUS_ERR = 2'd2
  } status_e;

  localparam logic [2:0] F_OK        = 3'd0;
  localparam logic [2:0] F_TRANSIENT = 3'd1;
  localparam logic [2:0] F_RESET     = 3'd2;
  localparam logic [2:0] F_POWER     = 3'd3;
  localparam logic [2:0] F_MISSING   = 3'd4;
  localparam logic [2:0] F_MISMATCH  = 3'd5;

  localparam logic [6:0] ADDR_SLOT0 = 7'h2f;
  localparam logic [6:0] ADDR_SLOT1 = 7'h2e;
  localparam logic [6:0] ADDR_SLOT2 = 7'h2c;
  localparam logic [6:0] ADDR_SLOT3 = 7'h27;

  localparam logic [7:0] PIN_PWR_BUS0  = 8'h27;
  localparam logic [7:0] PIN_PWR_BUS1  = 8'h3f;
  localparam logic [7:0] PIN_RST_B0_L0 = 8'h55;
  localparam logic [7:0] PIN_RST_B0_L1 = 8'h54;
  localparam logic [7:0] PIN_RST_B1_L0 = 8'h3b;
  localparam logic [7:0] PIN_RST_B1_L1 = 8'h3e;

  localparam logic [7:0] REG_READ_VALUE = 8'h0c;
  localparam logic [7:0] REG_DIR        = 8'd0;
  localparam logic [7:0] REG_OUT_A      = 8'd9;
  localparam logic [7:0] REG_OUT_B      = 8'd10;

  localparam logic [5:0] CMD_WRITE  = 6'd1;
  localparam logic [5:0] CMD_VALUE  = 6'd2;
  localparam logic [5:0] CMD_UNLOCK = 6'd7;
  localparam logic [5:0] CMD_STATUS = 6'd8;
  localparam logic [9:0] UNLOCK_KEY = 10'd2;

  localparam logic [9:0] VAL_SENSOR_DEF = 10'd128;
  localparam logic [9:0] VAL_DAC_DEF    = 10'd512;
  localparam logic [7:0] DIR_DEF        = 8'd255;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        bus_id;
    logic [6:0]  dev_addr;
    logic [1:0]  write_len;
    logic [7:0]  write_byte0;
    logic [7:0]  write_byte1;
    logic [1:0]  read_len;
    logic [7:0]  pin_select;
    logic        pin_is_input;
    logic        pin_level;
    logic [2:0]  fault_code;
    logic [15:0] fault_count;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  read_byte0;
    logic [7:0]  read_byte1;
    logic [9:0]  chip_value;
    logic [15:0] forbidden_count;
  } res_t;

  // Returns {known, slot} for a target address.
  function automatic logic [2:0] slot_of(logic [6:0] addr);
    logic [2:0] r;
    r = 3'b000;
    if (addr == ADDR_SLOT0) r = 3'b100;
    else if (addr == ADDR_SLOT1) r = 3'b101;
    else if (addr == ADDR_SLOT2) r = 3'b110;
    else if (addr == ADDR_SLOT3) r = 3'b111;
    return r;
  endfunction

endpackage

// ----- hdl/i2cscm_if.sv -----
// Valid/ready channel interfaces for the request and result beats of the
// I2C section chip model. No dependencies.
interface i2cscm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        bus_id;
  logic [6:0]  dev_addr;
  logic [1:0]  write_len;
  logic [7:0]  write_byte0;
  logic [7:0]  write_byte1;
  logic [1:0]  read_len;
  logic [7:0]  pin_select;
  logic        pin_is_input;
  logic        pin_level;
  logic [2:0]  fault_code;
  logic [15:0] fault_count;

  modport source (
    output valid, req_type, bus_id, dev_addr, write_len, write_byte0, write_byte1,
           read_len, pin_select, pin_is_input, pin_level, fault_code, fault_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, bus_id, dev_addr, write_len, write_byte0, write_byte1,
           read_len, pin_select, pin_is_input, pin_level, fault_code, fault_count,
    output ready
  );
endinterface

interface i2cscm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_byte0;
  logic [7:0]  read_byte1;
  logic [9:0]  chip_value;
  logic [15:0] forbidden_count;

  modport source (
    output valid, status, read_byte0, read_byte1, chip_value, forbidden_count,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte0, read_byte1, chip_value, forbidden_count,
    output ready
  );
endinterface

// ----- hdl/i2c_section_chip_model_core.sv -----
// Top level of the I2C section chip model: request register, execute stage
// and result register. Depends on i2cscm_pkg, i2cscm_if and i2cscm_exec.
// A taken request sits in the request register and executes on moving to the
// result register. Throughput: one request per cycle unless results stall;
// each does a read-modify-write of the chip registers; one more waits behind a stall.
// Reset clears all chip state, the refusal counter and both pipeline stages.
module i2c_section_chip_model_core
  import i2cscm_pkg::*;
#(
  parameter int unsigned BUS_COUNT = BUS_COUNT_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  i2cscm_req_if.sink  req_i,
  i2cscm_res_if.source res_o
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  res_t out_res_q;
  res_t exec_res;
  logic advance;
  logic fire;

  assign advance     = !out_valid_q || res_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q.req_type     <= req_i.req_type;
      s1_req_q.bus_id       <= req_i.bus_id;
      s1_req_q.dev_addr     <= req_i.dev_addr;
      s1_req_q.write_len    <= req_i.write_len;
      s1_req_q.write_byte0  <= req_i.write_byte0;
      s1_req_q.write_byte1  <= req_i.write_byte1;
      s1_req_q.read_len     <= req_i.read_len;
      s1_req_q.pin_select   <= req_i.pin_select;
      s1_req_q.pin_is_input <= req_i.pin_is_input;
      s1_req_q.pin_level    <= req_i.pin_level;
      s1_req_q.fault_code   <= req_i.fault_code;
      s1_req_q.fault_count  <= req_i.fault_count;
    end
  end

  i2cscm_exec #(
    .BUS_COUNT(BUS_COUNT)
  ) u_exec (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (fire),
    .req_i (s1_req_q),
    .res_o (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= exec_res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_res_q.status;
  assign res_o.read_byte0      = out_res_q.read_byte0;
  assign res_o.read_byte1      = out_res_q.read_byte1;
  assign res_o.chip_value      = out_res_q.chip_value;
  assign res_o.forbidden_count = out_res_q.forbidden_count;

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("request side stalled with an empty result register");

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("executed request produced no result beat");

  a_stall_keeps_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_req_q))
    else $error("stalled request was lost or changed");
`endif

endmodule

// ----- hdl/i2cscm_exec.sv -----
// Chip state registers and the combinational execute logic for one request.
// Depends on i2cscm_pkg.
module i2cscm_exec
  import i2cscm_pkg::*;
#(
  parameter int unsigned BUS_COUNT = BUS_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  req_t req_i,
  output res_t res_o
);

  localparam int unsigned BusIdxW = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
  localparam int unsigned ChipN   = BUS_COUNT * SLOTS_PER_BUS;
  localparam int unsigned LineN   = BUS_COUNT * 2;

  logic        powered_q [BUS_COUNT];
  logic        powered_d [BUS_COUNT];
  logic        rst_asrt_q [LineN];
  logic        rst_asrt_d [LineN];
  logic [9:0]  value_q [ChipN];
  logic [9:0]  value_d [ChipN];
  logic        we_q [ChipN];
  logic        we_d [ChipN];
  logic [5:0]  selcmd_q [ChipN];
  logic [5:0]  selcmd_d [ChipN];
  logic [2:0]  fault_q [ChipN];
  logic [2:0]  fault_d [ChipN];
  logic [15:0] nack_q [ChipN];
  logic [15:0] nack_d [ChipN];
  logic [7:0]  dir_q [BUS_COUNT];
  logic [7:0]  dir_d [BUS_COUNT];
  logic [15:0] refusals_q;
  logic [15:0] refusals_d;

  logic [2:0]         slot_info;
  logic [1:0]         slot;
  logic               known;
  logic [BusIdxW-1:0] bidx;
  logic [BusIdxW+1:0] ci;
  logic [BusIdxW:0]   li;
  logic [2:0]         f_eff;
  logic               refuse;
  logic               rd_en;
  logic [9:0]         value;
  logic [5:0]         cmd;
  logic [9:0]         data;
  logic               pin_bus;
  logic               pin_line;
  logic               pin_pwr;
  logic               pin_rst;
  logic [BusIdxW-1:0] pidx;
  status_e            status;

  assign slot_info = slot_of(req_i.dev_addr);
  assign slot      = slot_info[1:0];
  assign known     = slot_info[2] && (32'(req_i.bus_id) < BUS_COUNT);
  assign bidx      = BusIdxW'(req_i.bus_id);
  assign ci        = {bidx, slot};
  assign li        = {bidx, slot[0]};
  assign cmd       = req_i.write_byte0[7:2];
  assign data      = {req_i.write_byte0[1:0], req_i.write_byte1};

  always_comb begin
    pin_pwr  = 1'b0;
    pin_rst  = 1'b0;
    pin_bus  = 1'b0;
    pin_line = 1'b0;
    case (req_i.pin_select)
      PIN_PWR_BUS0: begin
        pin_pwr = 1'b1;
      end
      PIN_PWR_BUS1: begin
        pin_pwr = 1'b1;
        pin_bus = 1'b1;
      end
      PIN_RST_B0_L0: begin
        pin_rst = 1'b1;
      end
      PIN_RST_B0_L1: begin
        pin_rst  = 1'b1;
        pin_line = 1'b1;
      end
      PIN_RST_B1_L0: begin
        pin_rst = 1'b1;
        pin_bus = 1'b1;
      end
      PIN_RST_B1_L1: begin
        pin_rst  = 1'b1;
        pin_bus  = 1'b1;
        pin_line = 1'b1;
      end
      default: begin
      end
    endcase
    if (!(32'(pin_bus) < BUS_COUNT)) begin
      pin_pwr = 1'b0;
      pin_rst = 1'b0;
    end
  end

  assign pidx = BusIdxW'(pin_bus);

  always_comb begin
    powered_d  = powered_q;
    rst_asrt_d = rst_asrt_q;
    value_d    = value_q;
    we_d       = we_q;
    selcmd_d   = selcmd_q;
    fault_d    = fault_q;
    nack_d     = nack_q;
    dir_d      = dir_q;
    refusals_d = refusals_q;
    status     = ST_OK;
    refuse     = 1'b0;
    rd_en      = 1'b0;
    value      = '0;
    f_eff      = F_OK;

    case (req_i.req_type)
      REQ_TRANSFER: begin
        if (!known || !powered_q[bidx]) begin
          status = ST_NACK;
        end else if (slot[1] && rst_asrt_q[li]) begin
          status = ST_NACK;
        end else if (fault_q[ci] == F_TRANSIENT && nack_q[ci] != '0) begin
          nack_d[ci] = nack_q[ci] - 16'd1;
          status     = ST_NACK;
        end else begin
          if (fault_q[ci] == F_TRANSIENT) begin
            fault_d[ci] = F_OK;
          end else begin
            f_eff = fault_q[ci];
          end
          if (f_eff == F_RESET || f_eff == F_POWER || f_eff == F_MISSING) begin
            status = ST_NACK;
          end else if (req_i.write_len == 2'd0 && req_i.read_len == 2'd0) begin
            status = ST_OK;
          end else if (!slot[1]) begin
            if (req_i.write_len == 2'd2 && req_i.read_len == 2'd0 &&
                req_i.write_byte0 <= 8'd1) begin
              value_d[ci] = {1'b0, req_i.write_byte0[0], req_i.write_byte1};
            end else if (req_i.write_len != 2'd1 || req_i.write_byte0 != REG_READ_VALUE ||
                         req_i.read_len != 2'd2) begin
              refuse = 1'b1;
            end else begin
              rd_en = 1'b1;
              value = value_q[ci];
            end
          end else if (!slot[0]) begin
            if (req_i.write_len == 2'd2 && req_i.read_len == 2'd0) begin
              selcmd_d[ci] = cmd;
              if (cmd == CMD_UNLOCK && data == UNLOCK_KEY) begin
                we_d[ci] = 1'b1;
              end else if (cmd == CMD_WRITE && we_q[ci]) begin
                value_d[ci] = data;
              end else if (cmd != CMD_VALUE && cmd != CMD_STATUS) begin
                refuse = 1'b1;
              end
            end else if (req_i.write_len != 2'd0 || req_i.read_len != 2'd2 ||
                         (selcmd_q[ci] != CMD_VALUE && selcmd_q[ci] != CMD_STATUS)) begin
              refuse = 1'b1;
            end else begin
              rd_en = 1'b1;
              if (selcmd_q[ci] == CMD_VALUE) value = value_q[ci];
              else value = we_q[ci] ? UNLOCK_KEY : 10'd0;
            end
          end else begin
            if (req_i.write_len == 2'd2 && req_i.read_len == 2'd0) begin
              if (req_i.write_byte0 == REG_DIR) begin
                dir_d[bidx] = req_i.write_byte1;
              end else if (req_i.write_byte0 == REG_OUT_A || req_i.write_byte0 == REG_OUT_B) begin
                value_d[ci] = {2'b00, req_i.write_byte1};
              end else begin
                refuse = 1'b1;
              end
            end else if (req_i.write_len != 2'd1 || req_i.read_len != 2'd1 ||
                         (req_i.write_byte0 != REG_DIR && req_i.write_byte0 != REG_OUT_A &&
                          req_i.write_byte0 != REG_OUT_B)) begin
              refuse = 1'b1;
            end else begin
              rd_en = 1'b1;
              if (req_i.write_byte0 == REG_DIR) value = {2'b00, dir_q[bidx]};
              else value = value_q[ci];
            end
          end
          if (refuse) begin
            status = ST_BUS_ERR;
            if (refusals_q != COUNT_MAX) refusals_d = refusals_q + 16'd1;
          end
          if (f_eff == F_MISMATCH) value[0] = ~value[0];
        end
      end
      REQ_PIN: begin
        if (pin_pwr) begin
          for (int k = 0; k < SLOTS_PER_BUS; k++) begin
            if (powered_q[pidx] && !req_i.pin_is_input &&
                fault_q[{pidx, 2'(k)}] == F_POWER) begin
              fault_d[{pidx, 2'(k)}] = F_OK;
            end
            if (!powered_q[pidx] && req_i.pin_is_input) begin
              value_d[{pidx, 2'(k)}] = (k < 2) ? VAL_SENSOR_DEF :
                                      (k == 2) ? VAL_DAC_DEF : 10'd0;
              we_d[{pidx, 2'(k)}] = 1'b0;
            end
          end
          if (!powered_q[pidx] && req_i.pin_is_input) dir_d[pidx] = DIR_DEF;
          powered_d[pidx] = req_i.pin_is_input;
        end else if (pin_rst) begin
          if (!req_i.pin_level) begin
            if (fault_q[{pidx, 1'b1, pin_line}] == F_RESET) begin
              fault_d[{pidx, 1'b1, pin_line}] = F_OK;
            end
            value_d[{pidx, 1'b1, pin_line}] = pin_line ? 10'd0 : VAL_DAC_DEF;
            we_d[{pidx, 1'b1, pin_line}]    = 1'b0;
            if (pin_line) dir_d[pidx] = DIR_DEF;
          end
          rst_asrt_d[{pidx, pin_line}] = !req_i.pin_level;
        end
      end
      REQ_FAULT: begin
        if (known) begin
          fault_d[ci] = req_i.fault_code;
          nack_d[ci]  = req_i.fault_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.status          = status;
    res_o.read_byte0      = '0;
    res_o.read_byte1      = '0;
    if (rd_en && !refuse) begin
      if (req_i.read_len == 2'd2) begin
        res_o.read_byte0 = {6'd0, value[9:8]};
        res_o.read_byte1 = value[7:0];
      end else begin
        res_o.read_byte0 = value[7:0];
      end
    end
    res_o.chip_value      = known ? value_d[ci] : 10'd0;
    res_o.forbidden_count = refusals_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUS_COUNT; i++) begin
        powered_q[i] <= 1'b0;
        dir_q[i]     <= '0;
      end
      for (int i = 0; i < LineN; i++) begin
        rst_asrt_q[i] <= 1'b0;
      end
      for (int i = 0; i < ChipN; i++) begin
        value_q[i]  <= '0;
        we_q[i]     <= 1'b0;
        selcmd_q[i] <= '0;
        fault_q[i]  <= F_OK;
        nack_q[i]   <= '0;
      end
      refusals_q <= '0;
    end else if (en_i) begin
      powered_q  <= powered_d;
      dir_q      <= dir_d;
      rst_asrt_q <= rst_asrt_d;
      value_q    <= value_d;
      we_q       <= we_d;
      selcmd_q   <= selcmd_d;
      fault_q    <= fault_d;
      nack_q     <= nack_d;
      refusals_q <= refusals_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(refusals_q))
    else $error("refusal counter changed without a request");

  a_bus_err_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && status == ST_BUS_ERR |=>
      refusals_q == $past(refusals_q) + 16'd1 || $past(refusals_q) == COUNT_MAX)
    else $error("bus error did not bump the refusal counter");

  a_no_read_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && status != ST_OK |-> res_o.read_byte0 == '0 && res_o.read_byte1 == '0)
    else $error("read data returned on a failed transfer");
`endif

endmodule
